// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define FDRQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define FDRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define FDRQ_ASSERT_IMP(label, clk, rst, ante, cons)

`define FDRQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/fdrq_pkg.sv =====
package fdrq_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } state_type;

   localparam logic FUNC_ENQUEUE  = 1'b0;
   localparam logic FUNC_ADVANCE  = 1'b1;
   localparam logic KIND_RELEASE  = 1'b0;
   localparam logic KIND_OVERFLOW = 1'b1;

   localparam logic [1:0] FRAME_0 = 2'd0;
   localparam logic [1:0] FRAME_1 = 2'd1;
   localparam logic [1:0] FRAME_2 = 2'd2;

   typedef struct packed {
      logic enqueue;
      logic overflow;
      logic start;
      logic read;
      logic emit;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic old_empty;
      logic head_zero;
      logic drain_end;
      logic out_free;
   } status_type;

   // The oldest list is the one two steps ahead of the current one.
   function automatic logic [1:0] older_frame(input logic [1:0] f);
      logic [1:0] r;
      case (f)
         FRAME_1: r = FRAME_0;
         FRAME_2: r = FRAME_1;
         default: r = FRAME_2;
      endcase
      return r;
   endfunction

endpackage

// ===== src/frame_delayed_release_queue.sv =====
// Frame-delayed release queue.
// Input channel (req_): req_func 0 appends req_handle to the current frame's
// list; req_func 1 advances the frame and drains the oldest of three lists.
// Result channel (rsp_): each item is a released handle (rsp_kind 0) or an
// overflow notice (rsp_kind 1, handle zero) for an entry that found its list
// full; rsp_last marks the final result caused by one input item.
// An overflow shows its result in the next cycle. An advance starts, then
// reads each handle by the registered two-address read of the handle memory
// followed by the check and the output load, and then finishes; an empty
// list goes from start straight to finish, and a list that starts with a
// zero handle finishes after its first read.
// A drain stops at the list's count or at the first zero handle.
// All results leave through one output register; while it is held by a
// stalled receiver no further result is loaded and no new item is taken.
// Synchronous reset empties all three lists and makes frame zero current;
// no clearing pass is needed since entries are read only below a list's count.
// The handle memory holds three lists of SLOTS_PER_FRAME entries.
module frame_delayed_release_queue import fdrq_pkg::*; #(
   parameter int SLOTS_PER_FRAME = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_handle,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [31:0] rsp_released_handle,
   output logic        rsp_last
);

`include "assert_macros.svh"

   cmd_type    cmd;
   status_type status;

   fdrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fdrq_datapath #(
      .SLOTS_PER_FRAME (SLOTS_PER_FRAME)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_handle          (req_handle),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_released_handle (rsp_released_handle),
      .rsp_last            (rsp_last)
   );

   `FDRQ_ASSERT_IMP(a_overflow_form, clock, reset,
      rsp_valid && (rsp_kind == KIND_OVERFLOW), (rsp_released_handle == 32'd0) && rsp_last)
   `FDRQ_ASSERT_IMP(a_release_nonzero, clock, reset,
      rsp_valid && (rsp_kind == KIND_RELEASE), rsp_released_handle != 32'd0)
   `FDRQ_ASSERT_NEXT(a_advance_blocks, clock, reset,
      req_valid && req_ready && (req_func == FUNC_ADVANCE), !req_ready)

endmodule

// ===== src/fdrq_ctrl.sv =====
module fdrq_ctrl import fdrq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_func,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.out_free && (req_func == FUNC_ADVANCE)) begin
               state_in = status.old_empty ? ST_FINISH : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.head_zero) begin
               state_in = ST_FINISH;
            end else if (status.out_free) begin
               state_in = status.drain_end ? ST_FINISH : ST_READ;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = status.out_free;
            if (req_valid && status.out_free) begin
               if (req_func == FUNC_ADVANCE) begin
                  cmd.start = 1'b1;
               end else if (status.full) begin
                  cmd.overflow = 1'b1;
               end else begin
                  cmd.enqueue = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
         end
         ST_CHECK: begin
            if (!status.head_zero && status.out_free) begin
               cmd.emit = 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== src/fdrq_datapath.sv =====
module fdrq_datapath import fdrq_pkg::*; #(
   parameter int SLOTS_PER_FRAME = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [31:0] req_handle,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [31:0] rsp_released_handle,
   output logic        rsp_last
);

   localparam int CW    = $clog2(SLOTS_PER_FRAME + 1);
   localparam int IW    = $clog2(SLOTS_PER_FRAME);
   localparam int DEPTH = 3 * SLOTS_PER_FRAME;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [CW-1:0] FULL_COUNT = CW'(SLOTS_PER_FRAME);
   localparam logic [AW-1:0] BASE_1     = AW'(SLOTS_PER_FRAME);
   localparam logic [AW-1:0] BASE_2     = AW'(2 * SLOTS_PER_FRAME);

   logic [31:0]   mem [DEPTH];

   logic [CW-1:0] fill_ff;
   logic [1:0]    cur_ff;
   logic [CW-1:0] counts_ff [3];
   logic [1:0]    old_ff;
   logic [CW-1:0] cnt_ff;
   logic [IW-1:0] idx_ff;
   logic [31:0]   head_ff;
   logic [31:0]   next_ff;
   logic          rsp_valid_ff;
   logic          rsp_kind_ff;
   logic [31:0]   rsp_handle_ff;
   logic          rsp_last_ff;

   logic [1:0]    old_frame;
   logic [CW-1:0] old_cnt;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr0;
   logic [AW-1:0] rd_addr1;
   logic          tail;
   logic          emit_last;

   function automatic logic [AW-1:0] base_of(input logic [1:0] f);
      logic [AW-1:0] r;
      case (f)
         FRAME_1: r = BASE_1;
         FRAME_2: r = BASE_2;
         default: r = '0;
      endcase
      return r;
   endfunction

   always_comb begin
      old_frame = older_frame(cur_ff);
      case (old_frame)
         FRAME_1: old_cnt = counts_ff[1];
         FRAME_2: old_cnt = counts_ff[2];
         default: old_cnt = counts_ff[0];
      endcase
   end

   assign wr_addr   = base_of(cur_ff) + AW'(fill_ff);
   assign rd_addr0  = base_of(old_ff) + AW'(idx_ff);
   assign tail      = ((CW'(idx_ff) + CW'(1)) == cnt_ff);
   assign rd_addr1  = tail ? rd_addr0 : (rd_addr0 + AW'(1));
   assign emit_last = tail || (next_ff == 32'd0);

   assign status.full      = (fill_ff == FULL_COUNT);
   assign status.old_empty = (old_cnt == '0);
   assign status.head_zero = (head_ff == 32'd0);
   assign status.drain_end = emit_last;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.enqueue) begin
         mem[wr_addr] <= req_handle;
      end
      if (cmd.read) begin
         head_ff <= mem[rd_addr0];
         next_ff <= mem[rd_addr1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         old_ff <= old_frame;
         cnt_ff <= old_cnt;
         idx_ff <= '0;
      end else if (cmd.emit) begin
         idx_ff <= idx_ff + IW'(1);
      end
      if (cmd.overflow) begin
         rsp_kind_ff   <= KIND_OVERFLOW;
         rsp_handle_ff <= 32'd0;
         rsp_last_ff   <= 1'b1;
      end else if (cmd.emit) begin
         rsp_kind_ff   <= KIND_RELEASE;
         rsp_handle_ff <= head_ff;
         rsp_last_ff   <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         cur_ff       <= FRAME_0;
         rsp_valid_ff <= 1'b0;
         for (int f = 0; f < 3; f++) begin
            counts_ff[f] <= '0;
         end
      end else begin
         if (cmd.overflow || cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.enqueue) begin
            fill_ff <= fill_ff + CW'(1);
            for (int f = 0; f < 3; f++) begin
               if (cur_ff == 2'(f)) begin
                  counts_ff[f] <= fill_ff + CW'(1);
               end
            end
         end else if (cmd.finish) begin
            fill_ff <= '0;
            cur_ff  <= old_ff;
            for (int f = 0; f < 3; f++) begin
               if (old_ff == 2'(f)) begin
                  counts_ff[f] <= '0;
               end
            end
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_released_handle = rsp_handle_ff;
   assign rsp_last            = rsp_last_ff;

endmodule
